// ===== src/json_string_escaper_defines.svh =====
// ---------------------------------------------------------------------------
// JSON string escaper assertion macros
// Shared concurrent assertion helpers; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define JSE_ASSERT(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("jse assertion failed");
// Expression must never be true outside reset.
`define JSE_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(expr)) \
		else $error("jse assertion failed");
`else
`define JSE_ASSERT(lbl, clk_sig, rst_n_sig, prop)
`define JSE_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr)
`endif

`endif

// ===== src/jse_pkg.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper package
// Types, character constants and lookup functions shared by the escaper.
// ---------------------------------------------------------------------------
package jse_pkg;

	// Most characters one input byte can produce.
	localparam int CMD_CHARS   = 6;
	localparam int CMD_CNT_W   = $clog2(CMD_CHARS + 1);
	localparam int CMD_IDX_W   = $clog2(CMD_CHARS);

	// Command queue between the front and back ends.
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	// Pending UTF-8 sequence storage.
	localparam int HELD_DEPTH  = 3;
	localparam int HELD_CNT_W  = 2;
	localparam int CP_W        = 21;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LOWER_U   = 8'h75;
	localparam logic [7:0] CH_NONE      = 8'h00;

	localparam logic [7:0] CONT_LO      = 8'h80;
	localparam logic [7:0] CONT_HI      = 8'hBF;
	localparam logic [7:0] LEAD2_LO     = 8'hC2;
	localparam logic [7:0] LEAD2_HI     = 8'hDF;
	localparam logic [7:0] LEAD3_LO     = 8'hE0;
	localparam logic [7:0] LEAD3_HI     = 8'hEF;
	localparam logic [7:0] LEAD4_LO     = 8'hF0;
	localparam logic [7:0] LEAD4_HI     = 8'hF4;
	localparam logic [7:0] LEAD_E0      = 8'hE0;
	localparam logic [7:0] LEAD_ED      = 8'hED;
	localparam logic [7:0] LEAD_F0      = 8'hF0;
	localparam logic [7:0] LEAD_F4      = 8'hF4;

	// One byte's worth of output: up to six characters plus end flag.
	typedef struct packed {
		logic [CMD_CHARS-1:0][7:0] chars;
		logic [CMD_CNT_W-1:0]      count;
		logic                      last;
	} cmd_t;

	// Escape letter for a control or special ASCII byte, zero otherwise.
	function automatic logic [7:0] escape_letter(input logic [7:0] b);
		logic [7:0] e;
		unique case (b)
			8'h08:   e = 8'h62; // b
			8'h09:   e = 8'h74; // t
			8'h0A:   e = 8'h6E; // n
			8'h0C:   e = 8'h66; // f
			8'h0D:   e = 8'h72; // r
			8'h22:   e = 8'h22; // quote
			8'h2F:   e = 8'h2F; // slash
			8'h5C:   e = 8'h5C; // backslash
			default: e = CH_NONE;
		endcase
		return e;
	endfunction

	// Lower-case hex digit for a nibble.
	function automatic logic [7:0] hex_lower(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) begin
			c = 8'h30 + {4'd0, v};
		end else begin
			c = 8'h57 + {4'd0, v};
		end
		return c;
	endfunction

endpackage

// ===== src/jse_if.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper channels
// Valid/ready channels for raw bytes, queued commands and escaped characters.
// ---------------------------------------------------------------------------
interface jse_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source (output valid, in_byte, last_byte, input ready);
	modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface jse_cmd_if;
	logic           valid;
	logic           ready;
	jse_pkg::cmd_t  cmd;

	modport source (output valid, cmd, input ready);
	modport sink   (input valid, cmd, output ready);
endinterface

interface jse_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       has_char;
	logic       end_of_string;

	modport source (output valid, out_char, has_char, end_of_string, input ready);
	modport sink   (input valid, out_char, has_char, end_of_string, output ready);
endinterface

// ===== src/jse_front.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper front end
// Decodes UTF-8 and turns each raw byte into a list of output characters.
// ---------------------------------------------------------------------------
`include "json_string_escaper_defines.svh"

module jse_front (
	input  logic            clk,
	input  logic            arst_n,
	jse_byte_if.sink        raw,
	jse_cmd_if.source       cmd
);

	logic [jse_pkg::CP_W-1:0]       acc_q, acc_d;
	logic [1:0]                     rem_q, rem_d;
	logic [7:0]                     held_q [jse_pkg::HELD_DEPTH];
	logic [7:0]                     held_d [jse_pkg::HELD_DEPTH];
	logic [jse_pkg::HELD_CNT_W-1:0] hcnt_q, hcnt_d;

	logic [jse_pkg::CMD_CHARS-1:0][7:0] chars;
	logic [jse_pkg::CMD_CNT_W-1:0]      n;
	logic [7:0]                         b;
	logic [7:0]                         esc;
	logic [7:0]                         lo, hi;
	logic                               cont_ok;
	logic                               idle;
	logic                               accept;

	assign b      = raw.in_byte;
	assign esc    = jse_pkg::escape_letter(b);
	assign accept = raw.valid && raw.ready;

	// Allowed continuation range; the second byte is narrowed after some leads.
	always_comb begin
		lo = jse_pkg::CONT_LO;
		hi = jse_pkg::CONT_HI;
		if (hcnt_q == 2'd1) begin
			unique case (held_q[0])
				jse_pkg::LEAD_E0: lo = 8'hA0;
				jse_pkg::LEAD_ED: hi = 8'h9F;
				jse_pkg::LEAD_F0: lo = 8'h90;
				jse_pkg::LEAD_F4: hi = 8'h8F;
				default: ;
			endcase
		end
		cont_ok = (b >= lo) && (b <= hi);
	end

	always_comb begin
		acc_d  = acc_q;
		rem_d  = rem_q;
		held_d = held_q;
		hcnt_d = hcnt_q;
		chars  = '0;
		n      = '0;
		idle   = 1'b0;

		if (rem_q != 2'd0) begin
			if (cont_ok) begin
				acc_d = {acc_q[jse_pkg::CP_W-7:0], b[5:0]};
				rem_d = rem_q - 2'd1;
				if (rem_q == 2'd1) begin
					// Sequence complete: emit \uXXXX for the basic plane only.
					if (acc_d[jse_pkg::CP_W-1:16] == '0) begin
						chars[0] = jse_pkg::CH_BACKSLASH;
						chars[1] = jse_pkg::CH_LOWER_U;
						chars[2] = jse_pkg::hex_lower(acc_d[15:12]);
						chars[3] = jse_pkg::hex_lower(acc_d[11:8]);
						chars[4] = jse_pkg::hex_lower(acc_d[7:4]);
						chars[5] = jse_pkg::hex_lower(acc_d[3:0]);
						n        = 3'd6;
					end
					hcnt_d = '0;
					acc_d  = '0;
				end else if (hcnt_q < 2'd3) begin
					held_d[hcnt_q] = b;
					hcnt_d         = hcnt_q + 2'd1;
				end
			end else begin
				// Broken sequence: copy held bytes raw, then treat byte as fresh.
				for (int i = 0; i < jse_pkg::HELD_DEPTH; i++) begin
					if (2'(i) < hcnt_q) begin
						chars[n] = held_q[i];
						n        = n + 3'd1;
					end
				end
				hcnt_d = '0;
				rem_d  = '0;
				acc_d  = '0;
				idle   = 1'b1;
			end
		end else begin
			idle = 1'b1;
		end

		if (idle) begin
			priority if (b < jse_pkg::CONT_LO) begin
				if (b != 8'h00) begin
					if (esc != jse_pkg::CH_NONE) begin
						chars[n]        = jse_pkg::CH_BACKSLASH;
						chars[n + 3'd1] = esc;
						n               = n + 3'd2;
					end else begin
						chars[n] = b;
						n        = n + 3'd1;
					end
				end
			end else if (b >= jse_pkg::LEAD2_LO && b <= jse_pkg::LEAD2_HI) begin
				held_d[0] = b;
				hcnt_d    = 2'd1;
				rem_d     = 2'd1;
				acc_d     = {16'd0, b[4:0]};
			end else if (b >= jse_pkg::LEAD3_LO && b <= jse_pkg::LEAD3_HI) begin
				held_d[0] = b;
				hcnt_d    = 2'd1;
				rem_d     = 2'd2;
				acc_d     = {17'd0, b[3:0]};
			end else if (b >= jse_pkg::LEAD4_LO && b <= jse_pkg::LEAD4_HI) begin
				held_d[0] = b;
				hcnt_d    = 2'd1;
				rem_d     = 2'd3;
				acc_d     = {18'd0, b[2:0]};
			end else begin
				chars[n] = b;
				n        = n + 3'd1;
			end
		end

		// Truncated sequence at end of string: copy held bytes raw.
		if (raw.last_byte && (rem_d != 2'd0 || hcnt_d != '0)) begin
			for (int i = 0; i < jse_pkg::HELD_DEPTH; i++) begin
				if (2'(i) < hcnt_d) begin
					chars[n] = held_d[i];
					n        = n + 3'd1;
				end
			end
			hcnt_d = '0;
			rem_d  = '0;
			acc_d  = '0;
		end
	end

	// Drop bytes that produce nothing unless they close the string.
	assign raw.ready       = cmd.ready;
	assign cmd.valid       = raw.valid && (n != '0 || raw.last_byte);
	assign cmd.cmd.chars   = chars;
	assign cmd.cmd.count   = n;
	assign cmd.cmd.last    = raw.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			rem_q  <= '0;
			hcnt_q <= '0;
		end else if (accept) begin
			acc_q  <= acc_d;
			rem_q  <= rem_d;
			hcnt_q <= hcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_d;
		end
	end

	`JSE_ASSERT(a_pending_matches_held, clk, arst_n, (rem_q == 2'd0) == (hcnt_q == '0))

endmodule

// ===== src/jse_fifo.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper command queue
// Short queue that decouples byte intake from character output.
// ---------------------------------------------------------------------------
`include "json_string_escaper_defines.svh"

module jse_fifo (
	input  logic       clk,
	input  logic       arst_n,
	jse_cmd_if.sink    wr,
	jse_cmd_if.source  rd
);

	jse_pkg::cmd_t                  mem [jse_pkg::FIFO_DEPTH];
	logic [jse_pkg::FIFO_PTR_W-1:0] wptr_q, rptr_q;
	logic [jse_pkg::FIFO_CNT_W-1:0] count_q;
	logic                           push, pop;

	assign wr.ready = count_q < jse_pkg::FIFO_CNT_W'(jse_pkg::FIFO_DEPTH);
	assign rd.valid = count_q != '0;
	assign rd.cmd   = mem[rptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + jse_pkg::FIFO_PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + jse_pkg::FIFO_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + jse_pkg::FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - jse_pkg::FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= wr.cmd;
		end
	end

	`JSE_ASSERT(a_count_bound, clk, arst_n, count_q <= jse_pkg::FIFO_CNT_W'(jse_pkg::FIFO_DEPTH))
	`JSE_ASSERT(a_empty_ptrs, clk, arst_n, (count_q == '0) |-> (rptr_q == wptr_q))

endmodule

// ===== src/jse_back.sv =====
// ---------------------------------------------------------------------------
// JSON string escaper back end
// Walks each queued command and sends its characters one per transfer.
// ---------------------------------------------------------------------------
`include "json_string_escaper_defines.svh"

module jse_back (
	input  logic       clk,
	input  logic       arst_n,
	jse_cmd_if.sink    cmd,
	jse_char_if.source esc
);

	logic [jse_pkg::CMD_IDX_W-1:0] idx_q;
	logic                          valid_q;
	logic [7:0]                    char_q;
	logic                          has_q;
	logic                          eos_q;
	logic                          load;
	logic                          empty_cmd;
	logic                          done;

	// Load when the output register is free or being drained this cycle.
	assign load      = cmd.valid && (!valid_q || esc.ready);
	assign empty_cmd = cmd.cmd.count == '0;
	assign done      = empty_cmd ||
		(jse_pkg::CMD_CNT_W'(idx_q) == cmd.cmd.count - jse_pkg::CMD_CNT_W'(1));
	assign cmd.ready = load && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= done ? '0 : idx_q + jse_pkg::CMD_IDX_W'(1);
			end else if (esc.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= empty_cmd ? jse_pkg::CH_NONE : cmd.cmd.chars[idx_q];
			has_q  <= !empty_cmd;
			eos_q  <= cmd.cmd.last && done;
		end
	end

	assign esc.valid         = valid_q;
	assign esc.out_char      = char_q;
	assign esc.has_char      = has_q;
	assign esc.end_of_string = eos_q;

	`JSE_ASSERT(a_idx_in_cmd, clk, arst_n, (idx_q != '0) |-> (cmd.valid && (jse_pkg::CMD_CNT_W'(idx_q) < cmd.cmd.count)))
	`JSE_ASSERT(a_marker_ends, clk, arst_n, (valid_q && !has_q) |-> eos_q)

endmodule

// ===== src/json_string_escaper.sv =====
// Streams the bytes of a string in and JSON-escaped characters out, on two
// valid/ready channels. A byte is taken on every cycle in which the
// four-entry command queue has room, so bytes enter back to back; the output
// register gives one character per cycle while the receiver is ready. A byte
// that yields k characters holds the output side for k transfers (a bare end
// marker takes one transfer, a dropped byte none), so the sustained rate is
// set by the one-character output register. A character reaches the output
// through the queue write and then the output register.
// ---------------------------------------------------------------------------
// JSON string escaper
// Byte-in, character-out JSON string escaper with UTF-8 to \u decoding.
// ---------------------------------------------------------------------------
module json_string_escaper (
	input  logic       clk,
	input  logic       arst_n,
	jse_byte_if.sink   raw,
	jse_char_if.source esc
);

	// Front end -> queue, and queue -> back end command links.
	jse_cmd_if front_cmd ();
	jse_cmd_if back_cmd ();

	// Decode and classify each byte; stall intake only when the queue is full.
	jse_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.cmd    (front_cmd.source)
	);

	// Hold pending commands so intake and output stall independently.
	jse_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_cmd.sink),
		.rd     (back_cmd.source)
	);

	// Advance through each command one character per output transfer.
	jse_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (back_cmd.sink),
		.esc    (esc)
	);

endmodule

// ===== tb/json_string_escaper_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSON string escaper testbench
// Streams byte strings into the escaper and checks every escaped character
// against an in-bench predictor. Directed strings cover the escape table,
// UTF-8 limits, stray, broken and truncated sequences; random strings follow.
// Both channels idle at random; the receiver stalls once for a long stretch.
// ---------------------------------------------------------------------------
module json_string_escaper_test;

	localparam int STIM_ITEMS     = 230;   // stop filling the byte queue here
	localparam int HOLD_AT        = 100;   // character count that starts the long stall
	localparam int HOLD_CYCLES    = 200;   // length of the long receiver stall
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
	localparam int DRAIN_CYCLES   = 16;    // settle time after the last expected char
	localparam int MAX_REPORTS    = 10;

	// Bytes that the escape table turns into a backslash pair.
	localparam logic [7:0][7:0] ESCAPED_BYTES = {8'h08, 8'h09, 8'h0A, 8'h0C,
		8'h0D, 8'h22, 8'h2F, 8'h5C};
	localparam logic [7:0] DIGIT_ZERO = "0";
	localparam logic [7:0] DIGIT_A    = "a";

	// One raw byte waiting to be offered, with the idle cycles drawn for it.
	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic [1:0] gap;
	} raw_byte_t;

	// One escaped character as it should leave the block.
	typedef struct packed {
		logic [7:0] ch;
		logic       has_char;
		logic       eos;
	} esc_char_t;

	logic clk = 1'b0;
	logic arst_n;

	jse_byte_if raw_if ();
	jse_char_if esc_if ();

	json_string_escaper i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_if),
		.esc    (esc_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	raw_byte_t raw_bytes[$];      // bytes not yet offered
	esc_char_t pending_chars[$];  // characters owed by the block, oldest first
	esc_char_t step_chars[$];     // characters caused by the byte being decoded
	int        fault_count = 0;
	bit        rush = 1'b0;       // fill with zero gaps while set

	// Decoder state of the predictor.
	logic [20:0] cp_acc;
	logic [1:0]  cont_left;
	logic [7:0]  lead_bytes [3];
	logic [1:0]  lead_count;

	// -----------------------------------------------------------------------
	// Predictor
	// -----------------------------------------------------------------------

	function automatic void emit(input logic [7:0] c);
		step_chars.push_back(esc_char_t'{ch: c, has_char: 1'b1, eos: 1'b0});
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? DIGIT_ZERO + 8'(v) : DIGIT_A + 8'(v) - 8'd10;
	endfunction

	// Copy the held bytes of a pending sequence out raw and go idle.
	function automatic void flush_lead();
		for (int i = 0; i < lead_count; i++) begin
			emit(lead_bytes[i]);
		end
		lead_count = '0;
		cont_left  = '0;
		cp_acc     = '0;
	endfunction

	function automatic void open_sequence(input logic [7:0] b, input logic [1:0] need,
			input logic [7:0] mask);
		lead_bytes[0] = b;
		lead_count    = 2'd1;
		cont_left     = need;
		cp_acc        = {13'd0, b & mask};
	endfunction

	// Handle a byte with no sequence pending.
	function automatic void plain_byte(input logic [7:0] b);
		logic [7:0] letter;
		if (b < jse_pkg::CONT_LO) begin
			if (b != jse_pkg::CH_NONE) begin
				case (b)
					8'h08:   letter = "b";
					8'h09:   letter = "t";
					8'h0A:   letter = "n";
					8'h0C:   letter = "f";
					8'h0D:   letter = "r";
					8'h22:   letter = 8'h22;
					8'h2F:   letter = 8'h2F;
					8'h5C:   letter = jse_pkg::CH_BACKSLASH;
					default: letter = jse_pkg::CH_NONE;
				endcase
				if (letter != jse_pkg::CH_NONE) begin
					emit(jse_pkg::CH_BACKSLASH);
					emit(letter);
				end else begin
					emit(b);
				end
			end
		end else if (b >= jse_pkg::LEAD2_LO && b <= jse_pkg::LEAD2_HI) begin
			open_sequence(b, 2'd1, 8'h1F);
		end else if (b >= jse_pkg::LEAD3_LO && b <= jse_pkg::LEAD3_HI) begin
			open_sequence(b, 2'd2, 8'h0F);
		end else if (b >= jse_pkg::LEAD4_LO && b <= jse_pkg::LEAD4_HI) begin
			open_sequence(b, 2'd3, 8'h07);
		end else begin
			emit(b);
		end
	endfunction

	// Advance the predictor by one accepted byte and queue what it owes.
	function automatic void escape_step(input logic [7:0] b, input logic last);
		logic [7:0] lo;
		logic [7:0] hi;
		esc_char_t  tail;
		step_chars = {};
		if (cont_left != 0) begin
			lo = jse_pkg::CONT_LO;
			hi = jse_pkg::CONT_HI;
			// Narrowed second-byte windows exclude overlong forms, surrogates
			// and code points beyond the Unicode range.
			if (lead_count == 2'd1) begin
				case (lead_bytes[0])
					jse_pkg::LEAD_E0: lo = 8'hA0;
					jse_pkg::LEAD_ED: hi = 8'h9F;
					jse_pkg::LEAD_F0: lo = 8'h90;
					jse_pkg::LEAD_F4: hi = 8'h8F;
					default: ;
				endcase
			end
			if (b >= lo && b <= hi) begin
				cp_acc    = {cp_acc[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 0) begin
					// Only the basic plane gets a \u code; beyond it: drop.
					if (cp_acc[20:16] == '0) begin
						emit(jse_pkg::CH_BACKSLASH);
						emit(jse_pkg::CH_LOWER_U);
						emit(hex_char(cp_acc[15:12]));
						emit(hex_char(cp_acc[11:8]));
						emit(hex_char(cp_acc[7:4]));
						emit(hex_char(cp_acc[3:0]));
					end
					lead_count = '0;
					cp_acc     = '0;
				end else if (lead_count < 2'd3) begin
					lead_bytes[lead_count] = b;
					lead_count             = lead_count + 2'd1;
				end
			end else begin
				flush_lead();
				plain_byte(b);
			end
		end else begin
			plain_byte(b);
		end
		if (last) begin
			if (cont_left != 0 || lead_count != 0) begin
				flush_lead();
			end
			if (step_chars.size() == 0) begin
				step_chars.push_back(esc_char_t'{ch: jse_pkg::CH_NONE, has_char: 1'b0,
					eos: 1'b1});
			end else begin
				tail     = step_chars.pop_back();
				tail.eos = 1'b1;
				step_chars.push_back(tail);
			end
		end
		foreach (step_chars[i]) begin
			pending_chars.push_back(step_chars[i]);
		end
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus helpers
	// -----------------------------------------------------------------------

	function automatic void queue_byte(input logic [7:0] b);
		raw_byte_t item;
		item.value = b;
		item.last  = 1'b0;
		item.gap   = rush ? 2'd0 : 2'($urandom_range(0, 3));
		raw_bytes.push_back(item);
	endfunction

	// Mark the most recent byte as the end of its string.
	function automatic void close_string();
		raw_byte_t item;
		item      = raw_bytes.pop_back();
		item.last = 1'b1;
		raw_bytes.push_back(item);
	endfunction

	// Queue the shortest UTF-8 encoding of a code point.
	function automatic void queue_code_point(input logic [20:0] cp);
		if (cp < 21'h800) begin
			queue_byte({3'b110, cp[10:6]});
			queue_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			queue_byte({4'b1110, cp[15:12]});
			queue_byte({2'b10, cp[11:6]});
			queue_byte({2'b10, cp[5:0]});
		end else begin
			queue_byte({5'b11110, cp[20:18]});
			queue_byte({2'b10, cp[17:12]});
			queue_byte({2'b10, cp[11:6]});
			queue_byte({2'b10, cp[5:0]});
		end
	endfunction

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS) begin
			$display("%s", msg);
		end
	endfunction

	// -----------------------------------------------------------------------
	// Byte driver: offer queued bytes, honoring each byte's idle gap, and
	// feed the predictor on every transfer.
	// -----------------------------------------------------------------------
	int idle_count;

	always @(posedge clk or negedge arst_n) begin : raw_driver
		raw_byte_t item;
		logic      offer;
		if (!arst_n) begin
			raw_if.valid     <= 1'b0;
			raw_if.in_byte   <= 8'h00;
			raw_if.last_byte <= 1'b0;
			idle_count = 0;
			cp_acc     = '0;
			cont_left  = '0;
			lead_count = '0;
		end else begin
			offer = raw_if.valid;
			if (raw_if.valid && raw_if.ready) begin
				escape_step(raw_if.in_byte, raw_if.last_byte);
				offer = 1'b0;
			end
			// Hold valid low for the byte's gap, then present it; with a zero
			// gap valid simply stays high for back-to-back transfers.
			if (!offer && raw_bytes.size() != 0) begin
				if (idle_count < int'(raw_bytes[0].gap)) begin
					idle_count++;
				end else begin
					item = raw_bytes.pop_front();
					raw_if.in_byte   <= item.value;
					raw_if.last_byte <= item.last;
					offer      = 1'b1;
					idle_count = 0;
				end
			end
			raw_if.valid <= offer;
		end
	end

	// -----------------------------------------------------------------------
	// Character monitor: check each transfer against the oldest expectation
	// and stall ready at random, with calm stretches and one long hold-off.
	// -----------------------------------------------------------------------
	int stall_left;
	int chars_seen;

	always @(posedge clk or negedge arst_n) begin : esc_monitor
		esc_char_t want;
		logic      take;
		if (!arst_n) begin
			esc_if.ready <= 1'b0;
			stall_left = 0;
			chars_seen = 0;
		end else begin
			take = esc_if.ready;
			if (esc_if.valid && esc_if.ready) begin
				chars_seen++;
				if (pending_chars.size() == 0) begin
					note_fault($sformatf("unexpected char %02h has %0b end %0b",
						esc_if.out_char, esc_if.has_char, esc_if.end_of_string));
				end else begin
					want = pending_chars.pop_front();
					if (esc_if.out_char !== want.ch || esc_if.has_char !== want.has_char ||
							esc_if.end_of_string !== want.eos) begin
						note_fault($sformatf({"char mismatch: expected %02h has %0b end %0b,",
							" got %02h has %0b end %0b"}, want.ch, want.has_char, want.eos,
							esc_if.out_char, esc_if.has_char, esc_if.end_of_string));
					end
				end
				take = 1'b0;
				// Long hold-off: let the block fill up and push back on input.
				if (chars_seen == HOLD_AT) begin
					stall_left = HOLD_CYCLES;
				end else if (chars_seen % 128 < 40) begin
					stall_left = 0;
				end else begin
					stall_left = $urandom_range(0, 3);
				end
			end
			if (!take) begin
				if (stall_left != 0) begin
					stall_left--;
				end else begin
					take = 1'b1;
				end
			end
			esc_if.ready <= take;
		end
	end

	// -----------------------------------------------------------------------
	// Watchdog: end the run if neither channel moves for too long.
	// -----------------------------------------------------------------------
	int quiet_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if ((raw_if.valid && raw_if.ready) || (esc_if.valid && esc_if.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus and end of run
	// -----------------------------------------------------------------------
	initial begin : stimulus
		int          len;
		int          pick;
		bit          noisy;
		logic [7:0]  lead;
		logic [20:0] cp;

		// Assert reset once the clocked blocks are waiting on it.
		#0 arst_n = 1'b0;

		// Directed: plain ASCII, DEL, a dropped NUL and the full escape table.
		queue_byte("A");
		queue_byte(8'h7F);
		queue_byte(jse_pkg::CH_NONE);
		for (int i = 0; i < 8; i++) begin
			queue_byte(ESCAPED_BYTES[i]);
		end
		close_string();

		// Directed: smallest two-byte code, top of the basic plane, a stray
		// high byte, a broken three-byte lead and a four-byte lead cut short.
		queue_code_point(21'h00080);
		queue_code_point(21'h0FFFF);
		queue_byte(8'hFF);
		queue_byte(jse_pkg::LEAD_E0);
		queue_byte(jse_pkg::CONT_LO);
		queue_byte(jse_pkg::LEAD_F0);
		queue_byte(8'h90);
		close_string();

		// Directed: the highest code point is dropped, so the end marker is bare.
		queue_code_point(21'h10FFFF);
		close_string();

		// Directed: a lone NUL at end of string gives a bare end marker too.
		queue_byte(jse_pkg::CH_NONE);
		close_string();

		// Random strings: mostly well-formed text, some with noise.
		while (raw_bytes.size() < STIM_ITEMS) begin
			rush  = raw_bytes.size() >= 120 && raw_bytes.size() < 170;
			noisy = ($urandom_range(0, 4) == 0);
			len   = $urandom_range(1, 10);
			for (int i = 0; i < len; i++) begin
				pick = noisy ? $urandom_range(0, 99) : $urandom_range(0, 69);
				if (pick < 28) begin
					queue_byte(8'($urandom_range(8'h20, 8'h7E)));
				end else if (pick < 35) begin
					queue_byte(ESCAPED_BYTES[$urandom_range(0, 7)]);
				end else if (pick < 37) begin
					queue_byte(jse_pkg::CH_NONE);
				end else if (pick < 40) begin
					queue_byte(8'($urandom_range(1, 8'h1F)));
				end else if (pick < 48) begin
					queue_code_point(21'($urandom_range(21'h080, 21'h7FF)));
				end else if (pick < 62) begin
					// Favor the narrowed E0 and ED windows.
					case ($urandom_range(0, 3))
						0:       cp = 21'($urandom_range(21'h0800, 21'h0FFF));
						1:       cp = 21'($urandom_range(21'hD000, 21'hD7FF));
						2:       cp = 21'($urandom_range(21'hE000, 21'hFFFF));
						default: cp = 21'($urandom_range(21'h1000, 21'hCFFF));
					endcase
					queue_code_point(cp);
				end else if (pick < 70) begin
					// Favor the narrowed F0 and F4 windows.
					case ($urandom_range(0, 2))
						0:       cp = 21'($urandom_range(21'h10000, 21'h3FFFF));
						1:       cp = 21'($urandom_range(21'h100000, 21'h10FFFF));
						default: cp = 21'($urandom_range(21'h40000, 21'hFFFFF));
					endcase
					queue_code_point(cp);
				end else if (pick < 80) begin
					queue_byte(8'($urandom_range(0, 255)));
				end else if (pick < 90) begin
					// Likely broken sequence: lead, maybe a continuation, then a byte that may break it.
					lead = 8'($urandom_range(jse_pkg::LEAD2_LO, jse_pkg::LEAD4_HI));
					queue_byte(lead);
					if (lead >= jse_pkg::LEAD3_LO && $urandom_range(0, 1) == 1) begin
						queue_byte(8'($urandom_range(jse_pkg::CONT_LO, jse_pkg::CONT_HI)));
					end
					case ($urandom_range(0, 2))
						0:       queue_byte(8'($urandom_range(0, 8'h7F)));
						1:       queue_byte(8'($urandom_range(8'hC0, 8'hFF)));
						default: queue_byte(8'($urandom_range(jse_pkg::CONT_LO,
							jse_pkg::CONT_HI)));
					endcase
				end else begin
					queue_byte(8'($urandom_range(jse_pkg::LEAD2_LO, jse_pkg::LEAD4_HI)));
				end
			end
			// Cut some noisy strings short inside a sequence.
			if (noisy && $urandom_range(0, 1) == 1) begin
				queue_byte(8'($urandom_range(jse_pkg::LEAD3_LO, jse_pkg::LEAD4_HI)));
				if ($urandom_range(0, 1) == 1) begin
					queue_byte(8'($urandom_range(jse_pkg::CONT_LO, jse_pkg::CONT_HI)));
				end
			end
			close_string();
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Sample at the falling edge so the clocked blocks have settled.
		do begin
			@(negedge clk);
		end while (raw_bytes.size() != 0 || raw_if.valid || pending_chars.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_chars.size() != 0) begin
			note_fault($sformatf("%0d expected chars never arrived", pending_chars.size()));
		end
		if (fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
